// ===== sv/b64e_pkg.sv =====
// Shared types, constants and the character table for the Base64 stream encoder.
// No dependencies; used by every module of the encoder.
`default_nettype none

package b64e_pkg;

    localparam logic [7:0] PadChar = 8'h3D;
    localparam int QueueDepthDefault = 2;

    // One complete 3-byte group, ready to be expanded into four characters
    typedef struct packed {
        logic [23:0] bytes;      // first byte in bits 23..16
        logic [1:0]  pad_count;  // number of trailing '=' (0..2)
        logic        last;       // group closes the message
    } group_t;

    function automatic logic [7:0] b64_char(input logic [5:0] code);
        logic [7:0] c;
        c = {2'b00, code};
        case (code) inside
            [6'd0:6'd25]:  b64_char = 8'd65 + c;
            [6'd26:6'd51]: b64_char = 8'd71 + c;
            [6'd52:6'd61]: b64_char = c - 8'd4;
            6'd62:         b64_char = 8'h2B;
            default:       b64_char = 8'h2F;
        endcase
    endfunction

endpackage

`default_nettype wire

// ===== sv/base64_stream_encoder.sv =====
// Base64 stream encoder top level (standard alphabet, '=' padding).
// Depends on b64e_pkg, b64e_front, b64e_queue, b64e_back.
//
//   port group   dir   tdata fields (low bit up)   tlast
//   s_axis       in    data_byte[7:0]              is_final
//   m_axis       out   out_char[7:0]               out_last
//
// The emitter gives one character per cycle while m_axis is ready, four per group;
// full groups carry three bytes, and a final byte may close a shorter group.
// A group is written into the queue when its closing byte is accepted, then is loaded
// into the emitter once it is free, and its first character is registered onto m_axis.
// While m_axis stalls, the emitter holds its character; input stalls once the group
// queue is full. Reset clears the pending bytes, the queue pointers and the output valid.
`default_nettype none

module base64_stream_encoder
#(
    parameter int QueueDepth = b64e_pkg::QueueDepthDefault
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // data_byte[7:0]
    input  wire logic       s_tlast,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // out_char[7:0]
    output logic            m_tlast
);

    b64e_pkg::group_t push_group, q_group;
    logic             push, pop, q_full, q_valid;

    b64e_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_byte    (s_tdata),
        .in_final   (s_tlast),
        .q_full     (q_full),
        .push       (push),
        .push_group (push_group)
    );

    b64e_queue #(.Depth(QueueDepth)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_group (push_group),
        .full       (q_full),
        .pop        (pop),
        .q_valid    (q_valid),
        .q_group    (q_group)
    );

    b64e_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_group    (q_group),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_char   (m_tdata),
        .out_last   (m_tlast)
    );

endmodule

`default_nettype wire

// ===== sv/b64e_front.sv =====
// Front end of the Base64 encoder: takes input bytes and assembles 3-byte groups.
// Depends on b64e_pkg; pushes finished groups into b64e_queue.
`default_nettype none

module b64e_front
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [7:0]       in_byte,
    input  wire logic             in_final,
    input  wire logic             q_full,
    output logic                  push,
    output b64e_pkg::group_t      push_group
);

    logic [15:0] pending_bytes_reg, pending_bytes_next;
    logic [1:0]  pending_count_reg, pending_count_next;
    logic        accept;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        pending_bytes_next = pending_bytes_reg;
        pending_count_next = pending_count_reg;
        push               = 1'b0;
        push_group.bytes     = {pending_bytes_reg, in_byte};
        push_group.pad_count = 2'd0;
        push_group.last      = in_final;
        if (pending_count_reg[1])
        begin
            // third byte closes a full group
            push_group.bytes     = {pending_bytes_reg, in_byte};
            push_group.pad_count = 2'd0;
        end
        else if (pending_count_reg[0])
        begin
            push_group.bytes     = {pending_bytes_reg[15:8], in_byte, 8'h00};
            push_group.pad_count = 2'd1;
        end
        else
        begin
            push_group.bytes     = {in_byte, 16'h0000};
            push_group.pad_count = 2'd2;
        end
        if (accept)
        begin
            if (pending_count_reg[1] || in_final)
            begin
                push               = 1'b1;
                pending_bytes_next = 16'h0000;
                pending_count_next = 2'd0;
            end
            else if (pending_count_reg[0])
            begin
                pending_bytes_next = {pending_bytes_reg[15:8], in_byte};
                pending_count_next = 2'd2;
            end
            else
            begin
                pending_bytes_next = {in_byte, 8'h00};
                pending_count_next = 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_bytes_reg <= 16'h0000;
            pending_count_reg <= 2'd0;
        end
        else
        begin
            pending_bytes_reg <= pending_bytes_next;
            pending_count_reg <= pending_count_next;
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        pending_count_reg != 2'd3)
        else $error("pending byte count out of range");

    a_push_closes: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> pending_count_reg == 2'd0)
        else $error("group pushed but pending bytes kept");

endmodule

`default_nettype wire

// ===== sv/b64e_queue.sv =====
// Short group queue between the front end and the character emitter.
// Depends on b64e_pkg for the group type.
`default_nettype none

module b64e_queue
#(
    parameter int Depth = b64e_pkg::QueueDepthDefault
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire b64e_pkg::group_t  push_group,
    output logic                   full,
    input  wire logic              pop,
    output logic                   q_valid,
    output b64e_pkg::group_t       q_group
);

    localparam int PtrW   = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CountW = $clog2(Depth + 1);

    b64e_pkg::group_t  entries_reg [Depth];
    logic [PtrW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CountW-1:0] count_reg;

    assign full    = count_reg == CountW'(Depth);
    assign q_valid = count_reg != '0;
    assign q_group = entries_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            entries_reg[wr_ptr_reg] <= push_group;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full && !pop))
        else $error("group pushed into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && !q_valid))
        else $error("group popped from empty queue");

endmodule

`default_nettype wire

// ===== sv/b64e_back.sv =====
// Back end of the Base64 encoder: expands each group into four characters.
// Depends on b64e_pkg; pops groups from b64e_queue, drives the output register.
`default_nettype none

module b64e_back
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              q_valid,
    input  wire b64e_pkg::group_t  q_group,
    output logic                   pop,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [7:0]             out_char,
    output logic                   out_last
);

    b64e_pkg::group_t cur_reg;
    logic             cur_valid_reg, cur_valid_next;
    logic [1:0]       idx_reg, idx_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_char_reg;
    logic             out_last_reg;
    logic             advance, finishing, is_pad;
    logic [5:0]       code;
    logic [7:0]       char_sel;

    assign advance   = cur_valid_reg && (!out_valid_reg || out_ready);
    assign finishing = advance && (idx_reg == 2'd3);
    assign pop       = q_valid && (!cur_valid_reg || finishing);

    always_comb
    begin
        case (idx_reg)
            2'd0:    code = cur_reg.bytes[23:18];
            2'd1:    code = cur_reg.bytes[17:12];
            2'd2:    code = cur_reg.bytes[11:6];
            default: code = cur_reg.bytes[5:0];
        endcase
        is_pad   = ((idx_reg == 2'd3) && (cur_reg.pad_count != 2'd0))
                || ((idx_reg == 2'd2) && (cur_reg.pad_count == 2'd2));
        char_sel = is_pad ? b64e_pkg::PadChar : b64e_pkg::b64_char(code);
    end

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (out_ready)
            out_valid_next = 1'b0;
        if (advance)
        begin
            out_valid_next = 1'b1;
            idx_next       = idx_reg + 2'd1;
            if (finishing)
                cur_valid_next = 1'b0;
        end
        if (pop)
        begin
            cur_valid_next = 1'b1;
            idx_next       = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            cur_reg <= q_group;
        if (advance)
        begin
            out_char_reg <= char_sel;
            out_last_reg <= (idx_reg == 2'd3) && cur_reg.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign out_last  = out_last_reg;

    a_idx_held: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg != 2'd0 |-> cur_valid_reg)
        else $error("partly emitted group lost");

    a_last_on_fourth: assert property (@(posedge clk) disable iff (!rst_n)
        advance && cur_reg.last && idx_reg == 2'd3 |=> out_valid && out_last)
        else $error("closing character not marked last");

endmodule

`default_nettype wire

// ===== tb/b64_stream_checker.sv =====
// Checker for the Base64 stream encoder: watches both stream channels, predicts the
// characters from the accepted input words and compares each output word in order.
// Depends on b64e_pkg for the pad character.

module b64_stream_checker
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       s_tlast,
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,
    input  logic       m_tlast,
    output int         fail_count,
    output int         pending_chars
);

    localparam logic [8*64-1:0] B64_ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } enc_char_t;

    enc_char_t   expected_chars[$];
    enc_char_t   oldest_char;
    logic [15:0] held_bytes = 16'h0000;
    logic [1:0]  held_count = 2'd0;
    int          errors = 0;

    function automatic logic [7:0] alphabet_char(input logic [5:0] idx);
        return B64_ALPHABET[8*(63 - idx) +: 8];
    endfunction

    // Split a 24-bit group into four sextets, most significant first; pad the tail
    task automatic push_group(input logic [23:0] grp, input int nchars, input logic last);
        enc_char_t e;
        for (int k = 0; k < 4; k++)
        begin
            e.ch = (k < nchars) ? alphabet_char(grp[18 - 6*k +: 6]) : b64e_pkg::PadChar;
            e.last = (k == 3) && last;
            expected_chars.push_back(e);
        end
    endtask

    task automatic encode_byte(input logic [7:0] b, input logic fin);
        if (held_count >= 2'd2)
        begin
            push_group({held_bytes, b}, 4, fin);
            held_bytes = 16'h0000;
            held_count = 2'd0;
        end
        else if (fin)
        begin
            if (held_count == 2'd1)
                push_group({held_bytes[15:8], b, 8'h00}, 3, 1'b1);
            else
                push_group({b, 16'h0000}, 2, 1'b1);
            held_bytes = 16'h0000;
            held_count = 2'd0;
        end
        else
        begin
            if (held_count == 2'd0)
                held_bytes = {b, 8'h00};
            else
                held_bytes[7:0] = b;
            held_count = held_count + 2'd1;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            // Check output first: a word accepted this edge can never stem from this input
            if (m_tvalid && m_tready)
            begin
                if (expected_chars.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("checker: unexpected output word char=%h last=%b",
                                 m_tdata, m_tlast);
                end
                else
                begin
                    oldest_char = expected_chars.pop_front();
                    if (oldest_char.ch !== m_tdata || oldest_char.last !== m_tlast)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("checker: expected char=%h last=%b, got char=%h last=%b",
                                     oldest_char.ch, oldest_char.last, m_tdata, m_tlast);
                    end
                end
            end
            if (s_tvalid && s_tready)
                encode_byte(s_tdata, s_tlast);
        end
        fail_count    <= errors;
        pending_chars <= expected_chars.size();
    end

endmodule

// ===== tb/base64_stream_encoder_tb.sv =====
// Testbench top for the Base64 stream encoder: drives byte messages with random gaps and
// output stalls, and gives the verdict from the counts of b64_stream_checker.
// Depends on base64_stream_encoder, b64_stream_checker and b64e_pkg.

module base64_stream_encoder_tb;

    localparam int HOLD_CYCLES = 300;
    localparam int NUM_DIRECTED = 24;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;   // data_byte[7:0]
    logic       s_tlast = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;           // out_char[7:0]
    logic       m_tlast;

    int fail_count;
    int pending_chars;
    bit hold_req = 1'b0;
    bit full_rate = 1'b0;

    logic [8:0] directed_words [0:NUM_DIRECTED-1];   // {is_final, data_byte}

    always #5 clk = ~clk;

    base64_stream_encoder DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    b64_stream_checker checker_inst
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tlast       (s_tlast),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .fail_count    (fail_count),
        .pending_chars (pending_chars)
    );

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (full_rate || r < 50)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    task automatic send_word(input logic [7:0] data, input logic fin);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tlast  <= fin;
        do @(posedge clk); while (!s_tready);
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_message(input int len);
        for (int i = 0; i < len; i++)
            send_word(8'($urandom), i == len - 1);
    endtask

    // Drop valid and hold until every predicted character has come out
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending_chars != 0);
    endtask

    function automatic int pick_length();
        if ($urandom_range(0, 99) < 80)
            return $urandom_range(1, 6);
        else
            return $urandom_range(7, 12);
    endfunction

    // Output side: random bursts and gaps, a long hold-off on request, none at full rate
    initial
    begin
        int run;
        int gap;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (full_rate)
            begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                run = $urandom_range(1, 8);
                m_tready <= 1'b1;
                repeat (run) @(posedge clk);
                gap = pick_gap();
                if (gap > 0)
                begin
                    m_tready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
    end

    initial
    begin
        int sent;
        int len;

        // Zero and all-ones bytes at each group size, the '+' and '/' codes,
        // a full group followed by a padded tail, and one group plus a pair
        directed_words = '{9'h100, 9'h1FF,
                           9'h000, 9'h100, 9'h0FF, 9'h1FF,
                           9'h000, 9'h000, 9'h100, 9'h0FF, 9'h0FF, 9'h1FF,
                           9'h0FB, 9'h0EF, 9'h1BE,
                           9'h066, 9'h06F, 9'h06F, 9'h162,
                           9'h014, 9'h0FB, 9'h09C, 9'h003, 9'h1D9};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NUM_DIRECTED; i++)
            send_word(directed_words[i][7:0], directed_words[i][8]);
        wait_drained();

        // Flood the input while the output is held off so the group queue backs up
        hold_req = 1'b1;
        full_rate = 1'b1;
        sent = 0;
        while (sent < 18)
        begin
            len = pick_length();
            send_message(len);
            sent += len;
        end
        full_rate = 1'b0;
        wait_drained();

        // Both sides flat out
        full_rate = 1'b1;
        sent = 0;
        while (sent < 22)
        begin
            len = pick_length();
            send_message(len);
            sent += len;
        end
        full_rate = 1'b0;

        sent = 0;
        while (sent < 40)
        begin
            len = pick_length();
            send_message(len);
            sent += len;
            if ($urandom_range(0, 4) == 0)
                wait_drained();
        end

        wait_drained();
        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending_chars == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/b64e_pkg.sv
sv/b64e_front.sv
sv/b64e_queue.sv
sv/b64e_back.sv
sv/base64_stream_encoder.sv
tb/b64_stream_checker.sv
tb/base64_stream_encoder_tb.sv
